### sv/jse_pkg.sv
package jse_pkg;

	localparam int unsigned MAX_SOURCE_LEN = 65536;
	localparam int unsigned SRC_W          = $clog2(MAX_SOURCE_LEN + 1);
	localparam int unsigned POS_W          = 19;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned STEP_W         = 3;
	localparam int unsigned Q_DEPTH        = 2;
	localparam int unsigned Q_IDX_W        = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W        = $clog2(Q_DEPTH + 1);

	localparam logic [POS_W-1:0] CAP_RESET = POS_W'(393216);
	localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};

	localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd32;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [BYTE_W-1:0] HEX_ALPHA  = 8'd87;
	localparam logic [BYTE_W-1:0] CH_U       = 8'd117;
	localparam logic [BYTE_W-1:0] CH_BSL     = 8'd92;
	localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'd34;
	localparam logic [BYTE_W-1:0] CH_NUL     = 8'd0;
	localparam logic [3:0]        NIB_MASK   = 4'd15;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_PAIR,
		KIND_UNI,
		KIND_TERM
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              term;
	} desc_t;

	function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] d);
		logic [3:0] n;
		n = d & NIB_MASK;
		return (n > 4'd9) ? ({4'd0, n} + HEX_ALPHA) : ({4'd0, n} + CH_ZERO);
	endfunction

endpackage

### sv/jse_ifs.sv
interface jse_src_if;
	logic                          valid;
	logic                          ready;
	logic [jse_pkg::BYTE_W-1:0]    data_byte;
	logic                          source_last;

	modport source (output valid, output data_byte, output source_last, input ready);
	modport sink   (input valid, input data_byte, input source_last, output ready);
endinterface

interface jse_dst_if;
	logic                          valid;
	logic                          ready;
	logic [jse_pkg::BYTE_W-1:0]    out_byte;
	logic [jse_pkg::POS_W-1:0]     out_position;
	logic                          stored;
	logic                          is_terminator;
	logic [jse_pkg::POS_W-1:0]     total_length;
	logic                          run_last;

	modport source (output valid, output out_byte, output out_position, output stored,
		output is_terminator, output total_length, output run_last, input ready);
	modport sink   (input valid, input out_byte, input out_position, input stored,
		input is_terminator, input total_length, input run_last, output ready);
endinterface

### sv/json_string_escaper.sv
// channel  dir  fields                                              request
// src      in   data_byte, source_last                              one source byte
// dst      out  out_byte, out_position, stored, is_terminator,      one escaped byte
//               total_length, run_last
// cfg      in   cfg_we, cfg_data (dest_capacity)                    register write
//
// One result per cycle out of the back end while dst is ready: plain bytes then sustain
// one request per cycle, a quote or backslash expands to 2 bytes, a control byte to 6,
// plus 1 for a terminator. The expander step counter in the back end walks these bytes.
// A 2-entry queue separates classification from expansion; src stalls only when it fills.
// arst_n clears counts and queue and sets dest_capacity to 393216.
module json_string_escaper (
	input  logic                      clk,
	input  logic                      arst_n,
	jse_src_if.sink                   src,
	jse_dst_if.source                 dst,
	input  logic                      cfg_we,
	input  logic [jse_pkg::POS_W-1:0] cfg_data
);

	logic           push_valid;
	logic           push_ready;
	jse_pkg::desc_t push_desc;
	logic           head_valid;
	jse_pkg::desc_t head;
	logic           pop;

	jse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	jse_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (head_valid),
		.pop        (pop),
		.pop_desc   (head)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.dst        (dst)
	);

endmodule

### sv/jse_front.sv
module jse_front (
	input  logic            clk,
	input  logic            arst_n,
	jse_src_if.sink         src,
	output logic            push_valid,
	input  logic            push_ready,
	output jse_pkg::desc_t  push_desc
);

	logic [jse_pkg::SRC_W-1:0] src_cnt_q;
	logic [jse_pkg::SRC_W-1:0] cnt_nxt;
	logic                      bound;
	logic                      accept;

	assign push_valid = src.valid;
	assign src.ready  = push_ready;
	assign accept     = src.valid && push_ready;

	always_comb begin
		cnt_nxt = (src_cnt_q < jse_pkg::SRC_W'(jse_pkg::MAX_SOURCE_LEN)) ?
			src_cnt_q + jse_pkg::SRC_W'(1) : src_cnt_q;
		bound = (cnt_nxt >= jse_pkg::SRC_W'(jse_pkg::MAX_SOURCE_LEN));
		push_desc.data = src.data_byte;
		if (src.data_byte == jse_pkg::CH_NUL) begin
			push_desc.kind = jse_pkg::KIND_TERM;
			push_desc.term = 1'b1;
		end else begin
			push_desc.term = src.source_last || bound;
			if (src.data_byte < jse_pkg::CTRL_LIMIT) begin
				push_desc.kind = jse_pkg::KIND_UNI;
			end else if (src.data_byte == jse_pkg::CH_QUOTE ||
				src.data_byte == jse_pkg::CH_BSL) begin
				push_desc.kind = jse_pkg::KIND_PAIR;
			end else begin
				push_desc.kind = jse_pkg::KIND_PLAIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cnt_q <= '0;
		end else if (accept) begin
			if (push_desc.term) begin
				src_cnt_q <= '0;
			end else begin
				src_cnt_q <= cnt_nxt;
			end
		end
	end

endmodule

### sv/jse_fifo.sv
module jse_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  jse_pkg::desc_t  push_desc,
	output logic            pop_valid,
	input  logic            pop,
	output jse_pkg::desc_t  pop_desc
);

	jse_pkg::desc_t               mem_q [jse_pkg::Q_DEPTH];
	logic [jse_pkg::Q_IDX_W-1:0]  wr_q;
	logic [jse_pkg::Q_IDX_W-1:0]  rd_q;
	logic [jse_pkg::Q_CNT_W-1:0]  cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign push_ready = (cnt_q != jse_pkg::Q_CNT_W'(jse_pkg::Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_desc   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == jse_pkg::Q_IDX_W'(jse_pkg::Q_DEPTH - 1)) ? '0 :
					wr_q + jse_pkg::Q_IDX_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == jse_pkg::Q_IDX_W'(jse_pkg::Q_DEPTH - 1)) ? '0 :
					rd_q + jse_pkg::Q_IDX_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + jse_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - jse_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/jse_back.sv
module jse_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [jse_pkg::POS_W-1:0] cfg_data,
	input  logic                      head_valid,
	input  jse_pkg::desc_t            head,
	output logic                      pop,
	jse_dst_if.source                 dst
);

	logic [jse_pkg::POS_W-1:0]  cap_q;
	logic [jse_pkg::POS_W-1:0]  count_q;
	logic [jse_pkg::STEP_W-1:0] step_q;
	logic                       ov_q;

	logic [jse_pkg::STEP_W-1:0] body_len;
	logic                       term_step;
	logic                       item_end;
	logic                       adv;
	logic [jse_pkg::BYTE_W-1:0] byte_sel;

	always_comb begin
		unique case (head.kind)
			jse_pkg::KIND_PLAIN: body_len = 3'd1;
			jse_pkg::KIND_PAIR:  body_len = 3'd2;
			jse_pkg::KIND_UNI:   body_len = 3'd6;
			default:             body_len = 3'd0;
		endcase
		term_step = head.term && (step_q == body_len);
		item_end  = head.term ? term_step : (step_q == body_len - 3'd1);

		byte_sel = head.data;
		if (term_step) begin
			byte_sel = jse_pkg::CH_NUL;
		end else if (head.kind == jse_pkg::KIND_UNI) begin
			unique case (step_q)
				3'd0:    byte_sel = jse_pkg::CH_BSL;
				3'd1:    byte_sel = jse_pkg::CH_U;
				3'd2:    byte_sel = jse_pkg::CH_ZERO;
				3'd3:    byte_sel = jse_pkg::CH_ZERO;
				3'd4:    byte_sel = jse_pkg::hex_digit(head.data[7:4]);
				default: byte_sel = jse_pkg::hex_digit(head.data[3:0]);
			endcase
		end else if (head.kind == jse_pkg::KIND_PAIR && step_q == 3'd0) begin
			byte_sel = jse_pkg::CH_BSL;
		end
	end

	assign adv       = head_valid && (!ov_q || dst.ready);
	assign pop       = adv && item_end;
	assign dst.valid = ov_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			dst.out_byte      <= byte_sel;
			dst.out_position  <= count_q;
			dst.stored        <= (count_q < cap_q);
			dst.is_terminator <= term_step;
			dst.total_length  <= term_step ? count_q : '0;
			dst.run_last      <= item_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= jse_pkg::CAP_RESET;
			count_q <= '0;
			step_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (adv) begin
				ov_q <= 1'b1;
				step_q <= item_end ? '0 : step_q + jse_pkg::STEP_W'(1);
				if (term_step) begin
					count_q <= '0;
				end else if (count_q != jse_pkg::POS_MAX) begin
					count_q <= count_q + jse_pkg::POS_W'(1);
				end
			end else if (dst.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

### dv/tb_top.sv
module tb_top;
	import jse_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [POS_W-1:0]  out_position;
		logic              stored;
		logic              is_terminator;
		logic [POS_W-1:0]  total_length;
		logic              run_last;
	} esc_result_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 63;
	localparam int unsigned REPORT_MAX  = 50;

	class escape_tracker;
		logic [POS_W-1:0] capacity;
		logic [POS_W-1:0] out_count;
		int unsigned      src_count;
		esc_result_t      due_bytes[$];
		int unsigned      mismatches;
		int unsigned      requests;
		int unsigned      results;
		int unsigned      strings;
		int unsigned      bound_hits;
		int unsigned      stored_bytes;
		int unsigned      dropped_bytes;
		int unsigned      max_total;

		function new();
			capacity  = CAP_RESET;
			out_count = '0;
			src_count = 0;
		endfunction

		task report(input string msg);
			if (mismatches < REPORT_MAX)
				$display("mismatch @%0t: %s", $time, msg);
			mismatches++;
		endtask

		function logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
			return (nib < 4'd10) ? CH_ZERO + BYTE_W'(nib) : HEX_ALPHA + BYTE_W'(nib);
		endfunction

		function void push_out(input logic [BYTE_W-1:0] b, input logic term);
			esc_result_t r;
			r.out_byte      = b;
			r.out_position  = out_count;
			r.stored        = out_count < capacity;
			r.is_terminator = term;
			r.total_length  = term ? out_count : '0;
			r.run_last      = 1'b0;
			due_bytes.push_back(r);
			if (!term && out_count != POS_MAX)
				out_count++;
		endfunction

		function void take_source_byte(input logic [BYTE_W-1:0] b, input logic last);
			esc_result_t tail;
			logic        ends;
			ends = last;
			requests++;
			if (b != CH_NUL) begin
				if (b < CTRL_LIMIT) begin
					push_out(CH_BSL, 1'b0);
					push_out(CH_U, 1'b0);
					push_out(CH_ZERO, 1'b0);
					push_out(CH_ZERO, 1'b0);
					push_out(hex_char(b[7:4]), 1'b0);
					push_out(hex_char(b[3:0]), 1'b0);
				end else if (b == CH_QUOTE || b == CH_BSL) begin
					push_out(CH_BSL, 1'b0);
					push_out(b, 1'b0);
				end else begin
					push_out(b, 1'b0);
				end
				if (src_count < MAX_SOURCE_LEN)
					src_count++;
				if (src_count >= MAX_SOURCE_LEN) begin
					if (!last)
						bound_hits++;
					ends = 1'b1;
				end
			end else begin
				ends = 1'b1;
			end
			if (ends) begin
				if (out_count > max_total)
					max_total = out_count;
				push_out(CH_NUL, 1'b1);
				out_count = '0;
				src_count = 0;
				strings++;
			end
			tail = due_bytes.pop_back();
			tail.run_last = 1'b1;
			due_bytes.push_back(tail);
		endfunction

		task cmp(input string f, input logic [POS_W-1:0] got, input logic [POS_W-1:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0d want %0d", results, f, got, want));
		endtask

		task match_output(input esc_result_t got);
			esc_result_t want;
			if (due_bytes.size() == 0) begin
				report($sformatf("unexpected result byte %02h pos %0d",
					got.out_byte, got.out_position));
				return;
			end
			want = due_bytes.pop_front();
			cmp("out_byte", POS_W'(got.out_byte), POS_W'(want.out_byte));
			cmp("out_position", got.out_position, want.out_position);
			cmp("stored", POS_W'(got.stored), POS_W'(want.stored));
			cmp("is_terminator", POS_W'(got.is_terminator), POS_W'(want.is_terminator));
			cmp("total_length", got.total_length, want.total_length);
			cmp("run_last", POS_W'(got.run_last), POS_W'(want.run_last));
			if (want.stored)
				stored_bytes++;
			else
				dropped_bytes++;
			results++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [POS_W-1:0] cfg_data;
	idle_mode_t mode = IDLE_NONE;
	int unsigned cycles = 0;
	int unsigned cap_writes = 0;
	escape_tracker sb = new();

	jse_src_if src_if();
	jse_dst_if dst_if();

	json_string_escaper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src_if),
		.dst      (dst_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				sb.due_bytes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		esc_result_t got;
		if (arst_n) begin
			if (src_if.valid && src_if.ready)
				sb.take_source_byte(src_if.data_byte, src_if.source_last);
			if (dst_if.valid && dst_if.ready) begin
				got.out_byte      = dst_if.out_byte;
				got.out_position  = dst_if.out_position;
				got.stored        = dst_if.stored;
				got.is_terminator = dst_if.is_terminator;
				got.total_length  = dst_if.total_length;
				got.run_last      = dst_if.run_last;
				sb.match_output(got);
			end
		end
	end

	always @(negedge clk) begin
		case (mode)
			IDLE_RECEIVER: begin
				dst_if.ready <= $urandom_range(99) >= 85;
			end
			IDLE_BOTH: begin
				dst_if.ready <= $urandom_range(99) >= 9;
			end
			default: begin
				dst_if.ready <= 1'b1;
			end
		endcase
	end

	function automatic bit sender_skips();
		case (mode)
			IDLE_SENDER: return $urandom_range(99) < 85;
			IDLE_BOTH:   return $urandom_range(99) < 9;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return CH_NUL;
		if (r < 22)
			return BYTE_W'($urandom_range(1, 31));
		if (r < 30)
			return CH_QUOTE;
		if (r < 38)
			return CH_BSL;
		return BYTE_W'($urandom_range(32, 255));
	endfunction

	// entered and left at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		while (sender_skips()) begin
			src_if.valid <= 1'b0;
			@(negedge clk);
		end
		src_if.valid       <= 1'b1;
		src_if.data_byte   <= b;
		src_if.source_last <= last;
		@(posedge clk);
		while (!src_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		src_if.valid <= 1'b0;
		@(negedge clk);
		while (sb.due_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [POS_W-1:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.capacity = v;
		cap_writes++;
	endtask

	task automatic run_random(input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_all_results();
			send_byte(pick_byte(), $urandom_range(99) < 8);
		end
		wait_all_results();
	endtask

	initial begin
		logic [POS_W-1:0] caps[PHASES];
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_data           = '0;
		src_if.valid       = 1'b0;
		src_if.data_byte   = '0;
		src_if.source_last = 1'b0;
		dst_if.ready       = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty string, every escape class, byte extremes, max expansion
		write_capacity(POS_W'(4));
		send_byte(CH_NUL, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h1f, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_BSL, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h0a, 1'b0);
		send_byte(CH_NUL, 1'b1);
		send_byte(CH_QUOTE, 1'b1);
		send_byte(8'h10, 1'b1);
		send_byte(CH_BSL, 1'b1);
		send_byte(8'hab, 1'b0);
		send_byte(8'h5a, 1'b0);
		send_byte(CH_NUL, 1'b0);
		wait_all_results();

		caps[0] = '0;
		caps[1] = POS_W'(1);
		caps[2] = POS_W'(393215);
		caps[3] = POS_W'($urandom_range(2, 40));
		caps[4] = CAP_RESET;
		caps[5] = POS_W'($urandom_range(0, 12));
		caps[6] = POS_W'($urandom_range(0, 393216));
		caps[7] = POS_W'($urandom_range(5, 60));
		for (int unsigned p = 0; p < PHASES; p++) begin
			write_capacity(caps[p]);
			mode = idle_mode_t'(p % 4);
			run_random(PHASE_ITEMS);
		end
		mode = IDLE_NONE;
		wait_all_results();
		repeat (20) @(negedge clk);

		$display("covered %0d source bytes, %0d results, %0d strings (%0d cut at source bound)",
			sb.requests, sb.results, sb.strings, sb.bound_hits);
		$display("%0d capacity writes, %0d bytes stored, %0d dropped, longest total %0d",
			cap_writes, sb.stored_bytes, sb.dropped_bytes, sb.max_total);
		if (sb.mismatches == 0 && sb.due_bytes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.due_bytes.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
